@@ hdl/sqv_pkg.sv @@
// Package for the sprite quad vertex setup block: widths, payload structs and defaults.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps

package sqv_pkg;

    localparam int MAX_QUADS_DEF    = 16384;
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int COORD_IN_W  = 16;
    localparam int SIZE_W      = 12;
    localparam int ZOOM_W      = 16;
    localparam int ROT_W       = 12;
    localparam int COORD_OUT_W = 20;
    localparam int VTX_W       = 16;
    localparam int TOTAL_W     = 17;
    localparam int EXT_W       = SIZE_W + ZOOM_W;
    localparam int TRIG_W      = 16;

    typedef struct packed {
        logic signed [COORD_IN_W-1:0] centre_x;
        logic signed [COORD_IN_W-1:0] centre_y;
        logic [SIZE_W-1:0]            sprite_width;
        logic [SIZE_W-1:0]            sprite_height;
        logic [ZOOM_W-1:0]            zoom;
        logic [ROT_W-1:0]             rotation;
        logic                         restart;
    } t_sprite;

    typedef struct packed {
        logic signed [COORD_OUT_W-1:0] corner0_x;
        logic signed [COORD_OUT_W-1:0] corner0_y;
        logic signed [COORD_OUT_W-1:0] corner1_x;
        logic signed [COORD_OUT_W-1:0] corner1_y;
        logic signed [COORD_OUT_W-1:0] corner2_x;
        logic signed [COORD_OUT_W-1:0] corner2_y;
        logic signed [COORD_OUT_W-1:0] corner3_x;
        logic signed [COORD_OUT_W-1:0] corner3_y;
        logic [VTX_W-1:0]              first_vertex;
        logic [TOTAL_W-1:0]            first_index;
        logic                          batch_full;
    } t_quad;

    // One classified sprite waiting for the transform.
    typedef struct packed {
        logic signed [COORD_IN_W-1:0] centre_x;
        logic signed [COORD_IN_W-1:0] centre_y;
        logic [EXT_W-1:0]             ext_a;
        logic [EXT_W-1:0]             ext_b;
        logic signed [TRIG_W-1:0]     sin_val;
        logic signed [TRIG_W-1:0]     cos_val;
        logic [VTX_W-1:0]             first_vertex;
        logic [TOTAL_W-1:0]           first_index;
        logic                         batch_full;
    } t_item;

endpackage

@@ hdl/sqv_if.sv @@
// Valid/ready channel interfaces for sprite words in and quad words out.
// Depends on sqv_pkg for the payload structs.
`timescale 1ns / 1ps

interface sqv_sprite_if import sqv_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sprite data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sqv_quad_if import sqv_pkg::*; ();
    logic  valid;
    logic  ready;
    t_quad data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sprite_quad_vertex_setup.sv @@
// Sprite quad vertex setup: one sprite word in, one quad word of four rotated corners out.
// A finished quad is dequeued, passes the shared pair of multipliers (width extent, then
// height extent, against sine and cosine), forms its four corners one per cycle, finishes
// the last corner and is offered as the output word. A full batch skips the arithmetic and
// goes from the dequeue straight to the offered word. The front end takes a sprite in any
// cycle in which the queue has room, so sprites can arrive in bursts; sustained throughput
// is set by the transform sequencer, which dequeues the next sprite only after the output
// word is taken. Vertex and index totals are kept at the front, in arrival order.
// Depends on sqv_pkg, sqv_if, sqv_front, sqv_fifo and sqv_back.
`timescale 1ns / 1ps

module sprite_quad_vertex_setup import sqv_pkg::*; #(
    parameter int MAX_QUADS    = MAX_QUADS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sqv_sprite_if.sink  i_sprite,
    sqv_quad_if.source  o_quad
);

    logic  w_push;
    t_item w_push_data;
    logic  w_q_full;
    logic  w_pop;
    t_item w_pop_data;
    logic  w_q_empty;

    sqv_front #(
        .MAX_QUADS    (MAX_QUADS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sprite    (i_sprite),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_q_full    (w_q_full)
    );

    sqv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_q_empty)
    );

    sqv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_pop_data),
        .o_pop     (w_pop),
        .o_quad    (o_quad)
    );

endmodule

@@ hdl/sqv_front.sv @@
// Front end: accepts sprite words, keeps the vertex and index totals, flags full batches,
// forms the scaled extents and reads the sine/cosine ROM. Depends on sqv_pkg, sqv_if.
`timescale 1ns / 1ps

module sqv_front import sqv_pkg::*; #(
    parameter int MAX_QUADS    = MAX_QUADS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sqv_sprite_if.sink   i_sprite,
    output logic         o_push,
    output t_item        o_push_data,
    input  logic         i_q_full
);

    localparam int IDX_W  = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;
    localparam int PROD_W = ROT_W + 13;
    localparam logic [TOTAL_W-1:0] FULL_MARK = TOTAL_W'(4 * MAX_QUADS);
    localparam longint Q30_ONE     = 64'd1073741824;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    typedef logic [2*TRIG_W-1:0] t_trig_rom [SINE_ENTRIES];

    function automatic logic signed [TRIG_W-1:0] q30_to_q14(input longint v);
        longint unsigned m;
        longint unsigned r;
        m = (v < 0) ? longint'(-v) : longint'(v);
        r = (m + 64'd32768) >> 16;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        return (v < 0) ? -TRIG_W'(r) : TRIG_W'(r);
    endfunction

    // Shift-and-subtract quotient; only used while the ROM contents are computed.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave Taylor series in Q30, folded out to the full turn; evaluated at elaboration.
    function automatic t_trig_rom build_trig_rom();
        t_trig_rom       rom;
        longint unsigned phase;
        longint unsigned t;
        longint unsigned theta;
        longint unsigned th2;
        longint unsigned ts;
        longint unsigned tc;
        longint          s;
        longint          c;
        longint          so;
        longint          co;
        logic [1:0]      quad;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            phase = udiv64(64'(k) << 32, 64'(SINE_ENTRIES));
            quad  = phase[31:30];
            t     = phase & 64'h3FFF_FFFF;
            theta = (t * HALF_PI_Q30) >> 30;
            th2   = (theta * theta) >> 30;
            ts    = theta;
            tc    = Q30_ONE;
            s     = longint'(theta);
            c     = Q30_ONE;
            for (int n = 1; n <= 12; n++) begin
                ts = udiv64((ts * th2) >> 30, 64'((2 * n) * (2 * n + 1)));
                tc = udiv64((tc * th2) >> 30, 64'((2 * n - 1) * (2 * n)));
                if (n[0]) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            if (c < 0) begin
                c = 0;
            end
            case (quad)
                2'd0: begin
                    so = s;
                    co = c;
                end
                2'd1: begin
                    so = c;
                    co = -s;
                end
                2'd2: begin
                    so = -s;
                    co = -c;
                end
                default: begin
                    so = -c;
                    co = s;
                end
            endcase
            rom[k] = {q30_to_q14(so), q30_to_q14(co)};
        end
        return rom;
    endfunction

    localparam t_trig_rom TRIG_ROM = build_trig_rom();

    logic                    r_valid;
    logic [TOTAL_W-1:0]      r_vertex_total;
    logic [TOTAL_W-1:0]      r_index_total;
    logic [TOTAL_W-1:0]      n_vertex_total;
    logic [TOTAL_W-1:0]      n_index_total;
    logic [TOTAL_W-1:0]      w_vtx_base;
    logic [TOTAL_W-1:0]      w_idx_base;
    logic                    w_full;
    logic                    w_accept;
    logic [PROD_W-1:0]       w_rot_prod;
    logic [IDX_W-1:0]        w_rom_addr;
    logic [2*TRIG_W-1:0]     r_trig;
    logic signed [COORD_IN_W-1:0] r_cx;
    logic signed [COORD_IN_W-1:0] r_cy;
    logic [EXT_W-1:0]        r_ext_a;
    logic [EXT_W-1:0]        r_ext_b;
    logic [VTX_W-1:0]        r_first_vertex;
    logic [TOTAL_W-1:0]      r_first_index;
    logic                    r_full;

    assign o_push         = r_valid && !i_q_full;
    assign i_sprite.ready = !r_valid || !i_q_full;
    assign w_accept       = i_sprite.valid && i_sprite.ready;

    assign w_rot_prod = PROD_W'(i_sprite.data.rotation) * PROD_W'(SINE_ENTRIES);
    assign w_rom_addr = w_rot_prod[ROT_W +: IDX_W];

    always_comb begin
        w_vtx_base = i_sprite.data.restart ? '0 : r_vertex_total;
        w_idx_base = i_sprite.data.restart ? '0 : r_index_total;
        w_full     = (w_vtx_base >= FULL_MARK);
        n_vertex_total = r_vertex_total;
        n_index_total  = r_index_total;
        if (w_accept) begin
            n_vertex_total = w_full ? w_vtx_base : w_vtx_base + TOTAL_W'(4);
            n_index_total  = w_full ? w_idx_base : w_idx_base + TOTAL_W'(6);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_vertex_total <= '0;
            r_index_total  <= '0;
        end else begin
            r_vertex_total <= n_vertex_total;
            r_index_total  <= n_index_total;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_trig         <= TRIG_ROM[w_rom_addr];
            r_cx           <= i_sprite.data.centre_x;
            r_cy           <= i_sprite.data.centre_y;
            r_ext_a        <= EXT_W'(i_sprite.data.sprite_width) * EXT_W'(i_sprite.data.zoom);
            r_ext_b        <= EXT_W'(i_sprite.data.sprite_height) * EXT_W'(i_sprite.data.zoom);
            r_first_vertex <= w_full ? '0 : w_vtx_base[VTX_W-1:0];
            r_first_index  <= w_full ? '0 : w_idx_base;
            r_full         <= w_full;
        end
    end

    always_comb begin
        o_push_data.centre_x     = r_cx;
        o_push_data.centre_y     = r_cy;
        o_push_data.ext_a        = r_ext_a;
        o_push_data.ext_b        = r_ext_b;
        o_push_data.sin_val      = r_trig[2*TRIG_W-1:TRIG_W];
        o_push_data.cos_val      = r_trig[TRIG_W-1:0];
        o_push_data.first_vertex = r_first_vertex;
        o_push_data.first_index  = r_first_index;
        o_push_data.batch_full   = r_full;
    end

endmodule

@@ hdl/sqv_fifo.sv @@
// Short queue of classified sprites between the front end and the transform sequencer.
// Depends on sqv_pkg for the entry type.
`timescale 1ns / 1ps

module sqv_fifo import sqv_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_pop_data,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ hdl/sqv_back.sv @@
// Transform sequencer: rotates the scaled extents, forms the four corners one per cycle,
// rounds, translates and saturates them, then holds the quad word. Depends on sqv_pkg, sqv_if.
`timescale 1ns / 1ps

module sqv_back import sqv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_data,
    output logic        o_pop,
    sqv_quad_if.source  o_quad
);

    localparam int LEN_W = EXT_W + 1;
    localparam int P_W   = LEN_W + TRIG_W;
    localparam int D_W   = P_W + 1;
    localparam int SHIFT = 19;
    localparam int OFS_W = D_W - SHIFT;
    localparam int SUM_W = OFS_W + 1;
    localparam logic signed [D_W-1:0] ROUND_HALF = D_W'(1 << (SHIFT - 1));
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (COORD_OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (COORD_OUT_W - 1));

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL0 = 6'b000010,
        ST_MUL1 = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    function automatic logic signed [COORD_OUT_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[COORD_OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[COORD_OUT_W-1:0];
        end
        return v[COORD_OUT_W-1:0];
    endfunction

    t_state r_state;
    t_state n_state;
    logic [1:0]                    r_corner;
    logic                          r_dvalid;
    logic [1:0]                    r_dcorner;
    t_item                         r_item;
    logic signed [P_W-1:0]         r_p;
    logic signed [P_W-1:0]         r_q;
    logic signed [P_W-1:0]         r_r;
    logic signed [P_W-1:0]         r_t;
    logic signed [D_W-1:0]         r_dx;
    logic signed [D_W-1:0]         r_dy;
    logic signed [COORD_OUT_W-1:0] r_cx [4];
    logic signed [COORD_OUT_W-1:0] r_cy [4];

    logic signed [LEN_W-1:0] w_len;
    logic signed [P_W-1:0]   w_mc;
    logic signed [P_W-1:0]   w_ms;
    logic                    w_sx_pos;
    logic                    w_sy_pos;
    logic signed [D_W-1:0]   w_p;
    logic signed [D_W-1:0]   w_q;
    logic signed [D_W-1:0]   w_r;
    logic signed [D_W-1:0]   w_t;
    logic signed [D_W-1:0]   w_dx;
    logic signed [D_W-1:0]   w_dy;
    logic signed [OFS_W-1:0] w_ofs_x;
    logic signed [OFS_W-1:0] w_ofs_y;
    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;

    assign o_pop = (r_state == ST_IDLE) && !i_q_empty;

    // Two shared multipliers: extent A in the first step, extent B in the second.
    assign w_len = (r_state == ST_MUL0) ? $signed({1'b0, r_item.ext_a})
                                        : $signed({1'b0, r_item.ext_b});
    assign w_mc  = w_len * r_item.cos_val;
    assign w_ms  = w_len * r_item.sin_val;

    // Corners 1 and 2 take +x, corners 2 and 3 take +y.
    always_comb begin
        w_sx_pos = (r_corner == 2'd1) || (r_corner == 2'd2);
        w_sy_pos = r_corner[1];
        w_p  = D_W'(r_p);
        w_q  = D_W'(r_q);
        w_r  = D_W'(r_r);
        w_t  = D_W'(r_t);
        w_dx = (w_sx_pos ? w_p : -w_p) + (w_sy_pos ? -w_q : w_q) + ROUND_HALF;
        w_dy = (w_sx_pos ? w_r : -w_r) + (w_sy_pos ? w_t : -w_t) + ROUND_HALF;
    end

    // Arithmetic shift of the biased sum gives the half-up rounded offset.
    assign w_ofs_x = r_dx[D_W-1:SHIFT];
    assign w_ofs_y = r_dy[D_W-1:SHIFT];
    assign w_sum_x = SUM_W'(w_ofs_x) + SUM_W'(r_item.centre_x);
    assign w_sum_y = SUM_W'(w_ofs_y) + SUM_W'(r_item.centre_y);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_data.batch_full ? ST_DONE : ST_MUL0;
                end
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_SUM;
            ST_SUM: begin
                if (r_corner == 2'd3) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: n_state = ST_DONE;
            ST_DONE: begin
                if (o_quad.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_corner <= '0;
            r_dvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dvalid <= (r_state == ST_SUM);
            if (r_state == ST_SUM) begin
                r_corner <= r_corner + 2'd1;
            end else begin
                r_corner <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_data;
            for (int j = 0; j < 4; j++) begin
                r_cx[j] <= '0;
                r_cy[j] <= '0;
            end
        end
        if (r_state == ST_MUL0) begin
            r_p <= w_mc;
            r_r <= w_ms;
        end
        if (r_state == ST_MUL1) begin
            r_t <= w_mc;
            r_q <= w_ms;
        end
        if (r_state == ST_SUM) begin
            r_dx      <= w_dx;
            r_dy      <= w_dy;
            r_dcorner <= r_corner;
        end
        if (r_dvalid) begin
            r_cx[r_dcorner] <= sat_coord(w_sum_x);
            r_cy[r_dcorner] <= sat_coord(w_sum_y);
        end
    end

    assign o_quad.valid = (r_state == ST_DONE);

    always_comb begin
        o_quad.data.corner0_x    = r_cx[0];
        o_quad.data.corner0_y    = r_cy[0];
        o_quad.data.corner1_x    = r_cx[1];
        o_quad.data.corner1_y    = r_cy[1];
        o_quad.data.corner2_x    = r_cx[2];
        o_quad.data.corner2_y    = r_cy[2];
        o_quad.data.corner3_x    = r_cx[3];
        o_quad.data.corner3_y    = r_cy[3];
        o_quad.data.first_vertex = r_item.first_vertex;
        o_quad.data.first_index  = r_item.first_index;
        o_quad.data.batch_full   = r_item.batch_full;
    end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for sprite_quad_vertex_setup: drives sprite words, predicts each quad word
// and compares every field. Needs sqv_pkg, the sqv_if channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import sqv_pkg::*;

    localparam int QUADS        = MAX_QUADS_DEF;
    localparam int TRIG_ENTRIES = SINE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 250_000;
    localparam int RANDOM_WORDS = 2000;
    localparam longint SAT_HI   = 524287;
    localparam longint SAT_LO   = -524288;

    // Keeps its own copy of the vertex and index totals and the trig table, and queues the
    // quad word expected for every accepted sprite word.
    class quad_checker;
        int     sin_q14[TRIG_ENTRIES];
        int     cos_q14[TRIG_ENTRIES];
        bit [TOTAL_W-1:0] vtx_total;
        bit [TOTAL_W-1:0] idx_total;
        t_quad  pending_quads[$];
        int     mismatches;
        int     words_seen;

        function new();
            vtx_total  = '0;
            idx_total  = '0;
            mismatches = 0;
            words_seen = 0;
            build_trig();
        endfunction

        function int q30_to_q14(longint v);
            longint unsigned m;
            longint unsigned r;
            m = (v < 0) ? unsigned'(-v) : unsigned'(v);
            r = (m + 64'd32768) >> 16;
            if (r > 64'd16384)
                r = 64'd16384;
            return (v < 0) ? -int'(r) : int'(r);
        endfunction

        // Fixed-point Taylor series over the first quadrant, folded into the other three.
        function void build_trig();
            longint unsigned phase, t, theta, th2, ts, tc;
            longint s, c, so, co;
            bit [1:0] quadrant;
            for (int k = 0; k < TRIG_ENTRIES; k++) begin
                phase    = (longint'(k) << 32) / TRIG_ENTRIES;
                quadrant = phase[31:30];
                t        = phase & 64'h3FFF_FFFF;
                theta    = (t * 64'd1686629713) >> 30;
                th2      = (theta * theta) >> 30;
                ts       = theta;
                tc       = 64'd1073741824;
                s        = longint'(theta);
                c        = 64'sd1073741824;
                for (int n = 1; n <= 12; n++) begin
                    ts = ((ts * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    tc = ((tc * th2) >> 30) / longint'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1) begin
                        s -= longint'(ts);
                        c -= longint'(tc);
                    end else begin
                        s += longint'(ts);
                        c += longint'(tc);
                    end
                end
                if (s < 0) s = 0;
                if (c < 0) c = 0;
                case (quadrant)
                    2'd0: begin so = s;  co = c;  end
                    2'd1: begin so = c;  co = -s; end
                    2'd2: begin so = -s; co = -c; end
                    default: begin so = -c; co = s; end
                endcase
                sin_q14[k] = q30_to_q14(so);
                cos_q14[k] = q30_to_q14(co);
            end
        endfunction

        function logic signed [COORD_OUT_W-1:0] clamp20(longint v);
            if (v > SAT_HI) v = SAT_HI;
            if (v < SAT_LO) v = SAT_LO;
            return v[COORD_OUT_W-1:0];
        endfunction

        function t_quad predict_quad(t_sprite sp);
            t_quad  q;
            longint a, b, lx, ly, dx, dy, sn, cs, cx, cy;
            logic signed [COORD_OUT_W-1:0] px[4];
            logic signed [COORD_OUT_W-1:0] py[4];
            int     idx;
            q = '0;
            if (sp.restart) begin
                vtx_total = '0;
                idx_total = '0;
            end
            if (vtx_total >= 4 * QUADS) begin
                q.batch_full = 1'b1;
                return q;
            end
            a   = longint'(sp.sprite_width) * longint'(sp.zoom);
            b   = longint'(sp.sprite_height) * longint'(sp.zoom);
            cx  = longint'(sp.centre_x);
            cy  = longint'(sp.centre_y);
            idx = (int'(sp.rotation) * TRIG_ENTRIES) >> 12;
            if (idx >= TRIG_ENTRIES)
                idx = TRIG_ENTRIES - 1;
            sn = sin_q14[idx];
            cs = cos_q14[idx];
            // Corners run top-left, top-right, bottom-right, bottom-left.
            for (int j = 0; j < 4; j++) begin
                lx    = (j == 0 || j == 3) ? -a : a;
                ly    = (j < 2) ? -b : b;
                dx    = lx * cs - ly * sn;
                dy    = lx * sn + ly * cs;
                px[j] = clamp20(cx + ((dx + 262144) >>> 19));
                py[j] = clamp20(cy + ((dy + 262144) >>> 19));
            end
            q.corner0_x    = px[0];
            q.corner0_y    = py[0];
            q.corner1_x    = px[1];
            q.corner1_y    = py[1];
            q.corner2_x    = px[2];
            q.corner2_y    = py[2];
            q.corner3_x    = px[3];
            q.corner3_y    = py[3];
            q.first_vertex = vtx_total[VTX_W-1:0];
            q.first_index  = idx_total;
            vtx_total      = vtx_total + 17'd4;
            idx_total      = idx_total + 17'd6;
            return q;
        endfunction

        function void note_sprite(t_sprite sp);
            pending_quads.push_back(predict_quad(sp));
        endfunction

        function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quad word %0d: %s expected %0d, got %0d",
                             words_seen, field, want, got);
            end
        endfunction

        function void check_quad(t_quad got);
            t_quad want;
            words_seen++;
            if (pending_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quad word %0d arrived with no sprite word pending", words_seen);
                return;
            end
            want = pending_quads.pop_front();
            compare("corner0_x", want.corner0_x, got.corner0_x);
            compare("corner0_y", want.corner0_y, got.corner0_y);
            compare("corner1_x", want.corner1_x, got.corner1_x);
            compare("corner1_y", want.corner1_y, got.corner1_y);
            compare("corner2_x", want.corner2_x, got.corner2_x);
            compare("corner2_y", want.corner2_y, got.corner2_y);
            compare("corner3_x", want.corner3_x, got.corner3_x);
            compare("corner3_y", want.corner3_y, got.corner3_y);
            compare("first_vertex", want.first_vertex, got.first_vertex);
            compare("first_index", want.first_index, got.first_index);
            compare("batch_full", want.batch_full, got.batch_full);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   no_idle = 1'b0;
    int   cycle_count = 0;

    quad_checker chk = new();

    sqv_sprite_if sprite_ch();
    sqv_quad_if   quad_ch();

    sprite_quad_vertex_setup uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sprite (sprite_ch),
        .o_quad   (quad_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_sprite make_sprite(int cx, int cy, int w, int h, int z, int r, bit rs);
        t_sprite sp;
        sp.centre_x      = cx[COORD_IN_W-1:0];
        sp.centre_y      = cy[COORD_IN_W-1:0];
        sp.sprite_width  = w[SIZE_W-1:0];
        sp.sprite_height = h[SIZE_W-1:0];
        sp.zoom          = z[ZOOM_W-1:0];
        sp.rotation      = r[ROT_W-1:0];
        sp.restart       = rs;
        return sp;
    endfunction

    // Sizes and zoom lean toward small values now and then so that many quads stay clear
    // of saturation; the rest reach up to 1023 or cover the full range.
    function automatic t_sprite random_sprite(bit restart_ok);
        int w, h, z;
        case ($urandom_range(0, 3))
            0: begin w = $urandom_range(0, 63);   h = $urandom_range(0, 63);   end
            1: begin w = $urandom_range(0, 4095); h = $urandom_range(0, 4095); end
            default: begin w = $urandom_range(0, 1023); h = $urandom_range(0, 1023); end
        endcase
        case ($urandom_range(0, 7))
            0: z = 0;
            1, 2: z = $urandom_range(0, 1023);
            default: z = $urandom_range(0, 65535);
        endcase
        return make_sprite($urandom_range(0, 65535), $urandom_range(0, 65535), w, h, z,
                           $urandom_range(0, 4095),
                           restart_ok && ($urandom_range(0, 49) == 0));
    endfunction

    task automatic push_sprite(t_sprite sp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            sprite_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sprite_ch.valid <= 1'b1;
        sprite_ch.data  <= sp;
        do @(posedge i_clk); while (!(sprite_ch.valid && sprite_ch.ready));
        chk.note_sprite(sp);
    endtask

    // Sink side: each quad word waits out its own random stall before ready goes high.
    initial begin
        int gap;
        quad_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                quad_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            quad_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(quad_ch.valid && quad_ch.ready));
            chk.check_quad(quad_ch.data);
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        sprite_ch.valid <= 1'b0;
        sprite_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: zero extents, coordinate extremes, saturation, quadrant angles,
        // rounding of tiny offsets and counter restarts.
        push_sprite(make_sprite(0, 0, 0, 0, 0, 0, 1'b0));
        push_sprite(make_sprite(32767, -32768, 0, 0, 65535, 0, 1'b0));
        push_sprite(make_sprite(-32768, 32767, 4095, 4095, 0, 1024, 1'b0));
        push_sprite(make_sprite(-32768, 32767, 4095, 4095, 65535, 0, 1'b0));
        push_sprite(make_sprite(32767, -32768, 4095, 4095, 65535, 1024, 1'b0));
        push_sprite(make_sprite(0, 0, 4095, 4095, 65535, 2048, 1'b0));
        push_sprite(make_sprite(0, 0, 4095, 1, 65535, 3072, 1'b0));
        push_sprite(make_sprite(100, -100, 64, 32, 256, 512, 1'b0));
        push_sprite(make_sprite(100, -100, 64, 32, 256, 4095, 1'b0));
        push_sprite(make_sprite(0, 0, 1, 1, 256, 0, 1'b0));
        push_sprite(make_sprite(0, 0, 1, 1, 256, 3, 1'b0));
        push_sprite(make_sprite(0, 0, 1, 1, 1, 512, 1'b0));
        push_sprite(make_sprite(-1, -1, 1, 3, 1, 1536, 1'b0));
        push_sprite(make_sprite(5, 7, 2048, 2048, 128, 2560, 1'b0));
        push_sprite(make_sprite(-5, -7, 3, 3, 32768, 3584, 1'b1));
        push_sprite(make_sprite(12345, -12345, 2730, 1365, 43690, 2730, 1'b0));
        push_sprite(make_sprite(-21846, 21845, 1365, 2730, 21845, 1365, 1'b1));
        push_sprite(make_sprite(0, 0, 4095, 0, 65535, 1, 1'b0));
        push_sprite(make_sprite(0, 0, 0, 4095, 65535, 2, 1'b0));

        for (int i = 0; i < RANDOM_WORDS; i++)
            push_sprite(random_sprite(1'b1));

        // A short burst with no idle cycles on either side, then a counter restart.
        no_idle = 1'b1;
        for (int i = 0; i < 16; i++)
            push_sprite(random_sprite(1'b0));
        no_idle = 1'b0;
        push_sprite(make_sprite(-300, 300, 40, 20, 512, 777, 1'b1));
        for (int i = 0; i < 12; i++)
            push_sprite(random_sprite(1'b1));
        sprite_ch.valid <= 1'b0;

        while (chk.pending_quads.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (chk.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sqv_pkg.sv
hdl/sqv_if.sv
hdl/sqv_front.sv
hdl/sqv_fifo.sv
hdl/sqv_back.sv
hdl/sprite_quad_vertex_setup.sv
bench/tb.sv
